>>> src/sclstk_pkg.sv
// ----------------------------------------------------------------------------
// sclstk_pkg
// Shared types and constants for the sequence call and loop stack unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sclstk_pkg;

  // Field widths that do not follow from the parameters.
  localparam int OP_W         = 3;
  localparam int LOOP_COUNT_W = 16;
  localparam int ADVANCE_W    = 4;

  // Defaults for the top-level parameters.
  localparam int DEF_STACK_ENTRIES = 8;
  localparam int DEF_ADDR_BITS     = 24;

  // Operation codes carried in the op field. Codes 6 and 7 are undefined.
  typedef enum logic [OP_W-1:0] {
    OP_RESET      = 3'd0,
    OP_CALL       = 3'd1,
    OP_LOOP_START = 3'd2,
    OP_LOOP_END   = 3'd3,
    OP_RETURN     = 3'd4,
    OP_ADVANCE    = 3'd5
  } sclstk_op_t;

  // Status flags of one result.
  typedef struct packed {
    logic ok;
    logic looped_back;
  } sclstk_flags_t;

endpackage

`default_nettype wire

>>> src/sequence_call_loop_stack.sv
// ----------------------------------------------------------------------------
// sequence_call_loop_stack
// Program-counter unit with a shared call and loop stack for a sequence
// interpreter.
// ----------------------------------------------------------------------------
// The unit accepts one operation per clock cycle while the result side does
// not stall, and returns one result transaction for each (input register,
// then result register). Throughput is one operation per cycle because each
// operation is a single read-modify-write of the top stack entry together
// with one address add, all done in the cycle between the two registers.
// Stalls on the result side hold the result register; the input register
// still takes a new transaction whenever the result register can drain.
// The base address must only be written while no operation is in flight.
`default_nettype none

module sequence_call_loop_stack #(
  parameter int STACK_ENTRIES = sclstk_pkg::DEF_STACK_ENTRIES,
  parameter int ADDR_BITS     = sclstk_pkg::DEF_ADDR_BITS,
  localparam int PTR_W        = $clog2(STACK_ENTRIES + 1),
  localparam int IN_BITS      = sclstk_pkg::OP_W + ADDR_BITS + sclstk_pkg::LOOP_COUNT_W
                                + sclstk_pkg::ADVANCE_W,
  localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS     = 2 + ADDR_BITS + PTR_W,
  localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Configuration: base address.
  input  wire logic                   cfg_wr_en,
  input  wire logic [ADDR_BITS-1:0]   cfg_wr_data,
  // Operation stream.
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // in_tdata from bit 0: op, target_offset, loop_count, advance_by, zero fill
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // Result stream.
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // out_tdata from bit 0: ok, program_counter, depth, looped_back, zero fill
  output logic [OUT_TDATA_W-1:0]      out_tdata
);
  import sclstk_pkg::*;

  logic                    in_valid, advance;
  logic [OP_W-1:0]         op;
  logic [ADDR_BITS-1:0]    target_offset;
  logic [LOOP_COUNT_W-1:0] loop_count;
  logic [ADVANCE_W-1:0]    advance_by;

  logic [ADDR_BITS-1:0]    res_pc;
  logic [PTR_W-1:0]        res_depth;
  sclstk_flags_t           res_flags;

  logic                    out_valid_r;
  logic [ADDR_BITS-1:0]    out_pc_r;
  logic [PTR_W-1:0]        out_depth_r;
  sclstk_flags_t           out_flags_r;

  // The operation executes when the result register is free or draining.
  assign advance   = in_valid && (!out_valid_r || out_tready);
  assign in_tready = !in_valid || advance;

  sclstk_in_reg #(
    .ADDR_BITS (ADDR_BITS),
    .TDATA_W   (IN_TDATA_W)
  ) u_in_reg (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (in_tvalid && in_tready),
    .drain         (advance),
    .in_tdata      (in_tdata),
    .valid         (in_valid),
    .op            (op),
    .target_offset (target_offset),
    .loop_count    (loop_count),
    .advance_by    (advance_by)
  );

  sclstk_core #(
    .STACK_ENTRIES (STACK_ENTRIES),
    .ADDR_BITS     (ADDR_BITS),
    .PTR_W         (PTR_W)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .fire          (advance),
    .op            (op),
    .target_offset (target_offset),
    .loop_count    (loop_count),
    .advance_by    (advance_by),
    .res_pc        (res_pc),
    .res_depth     (res_depth),
    .res_flags     (res_flags)
  );

  // Result register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_pc_r    <= res_pc;
      out_depth_r <= res_depth;
      out_flags_r <= res_flags;
    end
  end

  // Pack the result transaction from the lowest bit up.
  always_comb begin
    out_tdata                              = '0;
    out_tdata[0]                           = out_flags_r.ok;
    out_tdata[ADDR_BITS:1]                 = out_pc_r;
    out_tdata[ADDR_BITS+PTR_W:ADDR_BITS+1] = out_depth_r;
    out_tdata[ADDR_BITS+PTR_W+1]           = out_flags_r.looped_back;
  end

  assign out_tvalid = out_valid_r;

  // The reported depth never exceeds the stack size.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_depth_r <= PTR_W'(STACK_ENTRIES)))
    else $error("stack depth beyond capacity");

  // A jump back is only reported for a successful operation.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_flags_r.looped_back) |-> out_flags_r.ok)
    else $error("looped_back without ok");

  // An executed operation always lands a result in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("executed operation lost its result");

  // Depth moves by at most one per operation, except for a stack reset.
  assert property (@(posedge clk) disable iff (!rst_n)
    (advance && $past(advance) && out_valid_r && res_flags.ok
     && (sclstk_op_t'(op) != OP_RESET))
    |-> ((res_depth == out_depth_r) || (res_depth == out_depth_r + 1'b1)
         || (res_depth == out_depth_r - 1'b1)))
    else $error("stack depth jumped");

endmodule

`default_nettype wire

>>> src/sclstk_in_reg.sv
// ----------------------------------------------------------------------------
// sclstk_in_reg
// Input register: captures one transaction and unpacks its fields.
// ----------------------------------------------------------------------------
`default_nettype none

module sclstk_in_reg #(
  parameter int ADDR_BITS  = 24,
  parameter int TDATA_W    = 48
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  load,
  input  wire logic                                  drain,
  input  wire logic [TDATA_W-1:0]                    in_tdata,
  output logic                                       valid,
  output logic [sclstk_pkg::OP_W-1:0]                op,
  output logic [ADDR_BITS-1:0]                       target_offset,
  output logic [sclstk_pkg::LOOP_COUNT_W-1:0]        loop_count,
  output logic [sclstk_pkg::ADVANCE_W-1:0]           advance_by
);
  import sclstk_pkg::*;

  localparam int OFF_LO = OP_W;
  localparam int CNT_LO = OFF_LO + ADDR_BITS;
  localparam int ADV_LO = CNT_LO + LOOP_COUNT_W;

  logic valid_r;
  logic [OP_W-1:0]         op_r;
  logic [ADDR_BITS-1:0]    offset_r;
  logic [LOOP_COUNT_W-1:0] count_r;
  logic [ADVANCE_W-1:0]    adv_r;

  // Occupancy of the register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (drain) begin
      valid_r <= 1'b0;
    end
  end

  // Payload capture, unpacked from the lowest bits up.
  always_ff @(posedge clk) begin
    if (load) begin
      op_r     <= in_tdata[OP_W-1:0];
      offset_r <= in_tdata[CNT_LO-1:OFF_LO];
      count_r  <= in_tdata[ADV_LO-1:CNT_LO];
      adv_r    <= in_tdata[ADV_LO+ADVANCE_W-1:ADV_LO];
    end
  end

  assign valid         = valid_r;
  assign op            = op_r;
  assign target_offset = offset_r;
  assign loop_count    = count_r;
  assign advance_by    = adv_r;

endmodule

`default_nettype wire

>>> src/sclstk_core.sv
// ----------------------------------------------------------------------------
// sclstk_core
// Program counter, base address and the shared call/loop stack, with the
// combinational update logic for one operation.
// ----------------------------------------------------------------------------
`default_nettype none

module sclstk_core #(
  parameter int STACK_ENTRIES = 8,
  parameter int ADDR_BITS     = 24,
  parameter int PTR_W         = 4
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_wr_en,
  input  wire logic [ADDR_BITS-1:0]                  cfg_wr_data,
  input  wire logic                                  fire,
  input  wire logic [sclstk_pkg::OP_W-1:0]           op,
  input  wire logic [ADDR_BITS-1:0]                  target_offset,
  input  wire logic [sclstk_pkg::LOOP_COUNT_W-1:0]   loop_count,
  input  wire logic [sclstk_pkg::ADVANCE_W-1:0]      advance_by,
  output logic [ADDR_BITS-1:0]                       res_pc,
  output logic [PTR_W-1:0]                           res_depth,
  output sclstk_pkg::sclstk_flags_t                  res_flags
);
  import sclstk_pkg::*;

  localparam int IDX_W = (STACK_ENTRIES > 1) ? $clog2(STACK_ENTRIES) : 1;

  logic [ADDR_BITS-1:0]    base_r;
  logic [ADDR_BITS-1:0]    pc_r, pc_nxt;
  logic [PTR_W-1:0]        ptr_r, ptr_nxt;
  logic [ADDR_BITS-1:0]    addr_stk_r [STACK_ENTRIES];
  logic [LOOP_COUNT_W-1:0] cnt_stk_r  [STACK_ENTRIES];

  sclstk_op_t              op_dec;
  logic                    full, empty;
  logic [IDX_W-1:0]        push_idx, top_idx;
  logic [ADDR_BITS-1:0]    top_addr;
  logic [LOOP_COUNT_W-1:0] top_cnt, cnt_dec;
  logic                    addr_we, cnt_push_we, cnt_top_we, clear_all;
  sclstk_flags_t           flags;

  assign op_dec   = sclstk_op_t'(op);
  assign full     = (ptr_r == PTR_W'(STACK_ENTRIES));
  assign empty    = (ptr_r == '0);
  assign push_idx = ptr_r[IDX_W-1:0];
  assign top_idx  = IDX_W'(ptr_r - 1'b1);
  assign top_addr = addr_stk_r[top_idx];
  assign top_cnt  = cnt_stk_r[top_idx];
  // Decrement that holds at zero, so counts of zero and one both run once.
  assign cnt_dec  = (top_cnt != '0) ? (top_cnt - 1'b1) : '0;

  // Next state and result for the operation in the input register.
  always_comb begin
    pc_nxt      = pc_r;
    ptr_nxt     = ptr_r;
    flags       = '0;
    addr_we     = 1'b0;
    cnt_push_we = 1'b0;
    cnt_top_we  = 1'b0;
    clear_all   = 1'b0;
    case (op_dec)
      OP_RESET: begin
        pc_nxt    = base_r;
        ptr_nxt   = '0;
        clear_all = 1'b1;
        flags.ok  = 1'b1;
      end
      OP_CALL: begin
        if (!full) begin
          addr_we  = 1'b1;
          ptr_nxt  = ptr_r + 1'b1;
          pc_nxt   = base_r + target_offset;
          flags.ok = 1'b1;
        end
      end
      OP_LOOP_START: begin
        if (!full) begin
          addr_we     = 1'b1;
          cnt_push_we = 1'b1;
          ptr_nxt     = ptr_r + 1'b1;
          flags.ok    = 1'b1;
        end
      end
      OP_LOOP_END: begin
        if (!empty) begin
          flags.ok = 1'b1;
          if (cnt_dec == '0) begin
            ptr_nxt = ptr_r - 1'b1;
          end else begin
            cnt_top_we        = 1'b1;
            pc_nxt            = top_addr;
            flags.looped_back = 1'b1;
          end
        end
      end
      OP_RETURN: begin
        if (!empty) begin
          ptr_nxt  = ptr_r - 1'b1;
          pc_nxt   = top_addr;
          flags.ok = 1'b1;
        end
      end
      OP_ADVANCE: begin
        pc_nxt   = pc_r + ADDR_BITS'(advance_by);
        flags.ok = 1'b1;
      end
      default: begin
        flags = '0;
      end
    endcase
  end

  // Base address register; the user must write it only while the unit is idle (not enforced here).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else if (cfg_wr_en) begin
      base_r <= cfg_wr_data;
    end
  end

  // Program counter and stack pointer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= '0;
      ptr_r <= '0;
    end else if (fire) begin
      pc_r  <= pc_nxt;
      ptr_r <= ptr_nxt;
    end
  end

  // Return addresses. An entry is always pushed before it can be popped.
  always_ff @(posedge clk) begin
    if (fire && addr_we) begin
      addr_stk_r[push_idx] <= pc_r;
    end
  end

  // Loop counts. A call leaves its slot alone, so every slot is cleared on
  // reset and by a stack reset to give the zero that a later loop end may read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STACK_ENTRIES; i++) begin
        cnt_stk_r[i] <= '0;
      end
    end else if (fire) begin
      if (clear_all) begin
        for (int i = 0; i < STACK_ENTRIES; i++) begin
          cnt_stk_r[i] <= '0;
        end
      end else if (cnt_push_we) begin
        cnt_stk_r[push_idx] <= loop_count;
      end else if (cnt_top_we) begin
        cnt_stk_r[top_idx] <= cnt_dec;
      end
    end
  end

  assign res_pc    = pc_nxt;
  assign res_depth = ptr_nxt;
  assign res_flags = flags;

endmodule

`default_nettype wire
